// ===== rtl/hba_pkg.sv =====
// shared constants, codes and pipeline types for the histogram bin arithmetic block
package hba_pkg;

  // number format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int ERR_BITS  = WORD_BITS - 1;
  localparam int FUNC_BITS = 3;
  localparam int STAT_BITS = 2;

  // divider row: one quotient bit per cell
  localparam int DIV_BITS  = WORD_BITS + FRAC_BITS;
  localparam int DIV_LANES = 3;

  // root row: one root bit per cell
  localparam int ARG_BITS   = 2 * WORD_BITS;
  localparam int ROOT_BITS  = WORD_BITS;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int SQRT_LANES = 2;

  // decode, divider row, five arithmetic stages, root row, output register
  localparam int STAGES = DIV_BITS + ROOT_BITS + 7;

  // lane numbers
  localparam int LN_QUO = 0;
  localparam int LN_EA  = 1;
  localparam int LN_EB  = 2;
  localparam int LN_ERR = 0;
  localparam int LN_VAL = 1;

  // fixed point constants
  localparam logic [WORD_BITS-1:0] POS_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] NEG_MAG = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS:0]   ONE_X   =
    {{(WORD_BITS-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [WORD_BITS-1:0] ONE_Q   = ONE_X[WORD_BITS-1:0];

  // operation codes
  typedef enum logic [FUNC_BITS-1:0] {
    FN_ADD  = 3'd0,
    FN_SUB  = 3'd1,
    FN_MUL  = 3'd2,
    FN_DIV  = 3'd3,
    FN_SQRT = 3'd4,
    FN_CLIP = 3'd5
  } func_t;

  // status codes
  localparam logic [STAT_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_SAT     = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_NEGROOT = 2'd2;

  // restoring divider lane: partial remainder and dividend/quotient shift word
  typedef struct packed {
    logic [WORD_BITS-1:0] rem;
    logic [DIV_BITS-1:0]  num;
  } div_lane_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]             dvsr;
    div_lane_t [DIV_LANES-1:0]        lane;
  } div_t;

  // restoring square root lane
  typedef struct packed {
    logic [ARG_BITS-1:0]  arg;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } sqrt_lane_t;

  typedef struct packed {
    sqrt_lane_t [SQRT_LANES-1:0] lane;
  } sqrt_t;

endpackage

// ===== rtl/hba_div_cell.sv =====
// one restoring division step on three lanes sharing a divisor
module hba_div_cell (
  input  logic          clk,
  input  logic          en,
  input  hba_pkg::div_t div_in,
  output hba_pkg::div_t div_out
);
  import hba_pkg::*;

  div_t               div_r;
  div_t               div_nxt;
  logic [WORD_BITS:0] part [DIV_LANES];
  logic [WORD_BITS:0] diff [DIV_LANES];
  logic               ge   [DIV_LANES];

  // shift in next dividend bit, subtract divisor when it fits
  always_comb begin
    div_nxt.dvsr = div_in.dvsr;
    for (int k = 0; k < DIV_LANES; k++) begin
      part[k] = {div_in.lane[k].rem, div_in.lane[k].num[DIV_BITS-1]};
      diff[k] = part[k] - {1'b0, div_in.dvsr};
      ge[k]   = part[k] >= {1'b0, div_in.dvsr};
      div_nxt.lane[k].rem = ge[k] ? diff[k][WORD_BITS-1:0] : part[k][WORD_BITS-1:0];
      div_nxt.lane[k].num = {div_in.lane[k].num[DIV_BITS-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign div_out = div_r;

endmodule

// ===== rtl/hba_sqrt_cell.sv =====
// one restoring square root step on two lanes
module hba_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  hba_pkg::sqrt_t sq_in,
  output hba_pkg::sqrt_t sq_out
);
  import hba_pkg::*;

  sqrt_t               sq_r;
  sqrt_t               sq_nxt;
  logic [REM_BITS+1:0] part  [SQRT_LANES];
  logic [REM_BITS+1:0] trial [SQRT_LANES];
  logic [REM_BITS+1:0] diff  [SQRT_LANES];
  logic                ge    [SQRT_LANES];

  // bring down two argument bits, try root*4+1
  always_comb begin
    for (int k = 0; k < SQRT_LANES; k++) begin
      part[k]  = {sq_in.lane[k].rem, sq_in.lane[k].arg[ARG_BITS-1 -: 2]};
      trial[k] = {2'b00, sq_in.lane[k].root, 2'b01};
      diff[k]  = part[k] - trial[k];
      ge[k]    = part[k] >= trial[k];
      sq_nxt.lane[k].rem  = ge[k] ? diff[k][REM_BITS-1:0] : part[k][REM_BITS-1:0];
      sq_nxt.lane[k].root = {sq_in.lane[k].root[ROOT_BITS-2:0], ge[k]};
      sq_nxt.lane[k].arg  = {sq_in.lane[k].arg[ARG_BITS-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq_out = sq_r;

endmodule

// ===== rtl/histogram_bin_arithmetic_with_errors.sv =====
// top level: bin-wise arithmetic with error propagation, pipelined through cell rows
// Pipeline: decode, 48-cell divider row, five arithmetic stages, 32-cell root row,
// output register.
// Throughput: one request per cycle while no result waits on out_stall.
// While a result waits on out_stall the whole pipeline holds and in_stall is raised.
// Reset clears the stage valid bits only; data registers are not reset.
module histogram_bin_arithmetic_with_errors (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [hba_pkg::FUNC_BITS-1:0]       in_func,
  input  logic signed [hba_pkg::WORD_BITS-1:0] in_value_a,
  input  logic [hba_pkg::ERR_BITS-1:0]        in_error_a,
  input  logic signed [hba_pkg::WORD_BITS-1:0] in_value_b,
  input  logic [hba_pkg::ERR_BITS-1:0]        in_error_b,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hba_pkg::WORD_BITS-1:0] out_result_value,
  output logic signed [hba_pkg::WORD_BITS-1:0] out_result_error,
  output logic [hba_pkg::STAT_BITS-1:0]       out_status
);
  import hba_pkg::*;

  // per-request side data that travels beside the cells
  typedef struct packed {
    func_t                func;
    logic [WORD_BITS-1:0] val_a;
    logic [ERR_BITS-1:0]  err_a;
    logic [ERR_BITS-1:0]  err_b;
    logic [WORD_BITS-1:0] mag_a;
    logic [WORD_BITS-1:0] mag_b;
    logic                 neg;
    logic [WORD_BITS-1:0] rv;
    logic [WORD_BITS-1:0] re;
    logic                 re_fixed;
    logic                 ovf;
    logic                 negroot;
  } item_t;

  // quotient stage results
  typedef struct packed {
    logic [WORD_BITS-1:0] qm;
    logic [ERR_BITS-1:0]  r1;
    logic [ERR_BITS-1:0]  r2;
    logic [WORD_BITS-1:0] cm;
    logic                 cneg;
  } quo_t;

  // first product stage
  typedef struct packed {
    logic [2*WORD_BITS-1:0]        pab;
    logic [WORD_BITS+ERR_BITS-1:0] paeb;
    logic [WORD_BITS+ERR_BITS-1:0] pbea;
    logic [WORD_BITS+ERR_BITS-1:0] pqr;
    logic [2*ERR_BITS-1:0]         pr1;
    logic [WORD_BITS-1:0]          cm;
    logic                          cneg;
  } prod_t;

  // square stage operands
  typedef struct packed {
    logic [ERR_BITS-1:0]  x;
    logic [ERR_BITS-1:0]  y;
    logic [ERR_BITS-1:0]  v;
    logic [WORD_BITS-1:0] cm;
    logic                 cneg;
  } sqop_t;

  // square stage products
  typedef struct packed {
    logic [2*ERR_BITS-1:0]         sx;
    logic [2*ERR_BITS-1:0]         sy;
    logic [WORD_BITS+ERR_BITS-1:0] scv;
    logic                          cneg;
  } sqres_t;

  // saturate a magnitude to the positive error range
  function automatic logic [ERR_BITS-1:0] sat_err(input logic [2*WORD_BITS-1:0] x);
    return (x > {{WORD_BITS{1'b0}}, POS_MAX}) ? POS_MAX[ERR_BITS-1:0] : x[ERR_BITS-1:0];
  endfunction

  function automatic logic over_err(input logic [2*WORD_BITS-1:0] x);
    return x > {{WORD_BITS{1'b0}}, POS_MAX};
  endfunction

  logic                 adv;
  logic [STAGES-1:0]    vld_r;
  logic [STAGES-1:0]    vld_nxt;

  item_t                dec_it;
  div_t                 dec_div;
  logic [WORD_BITS:0]   a_ext;
  logic [WORD_BITS:0]   b_ext;
  logic [WORD_BITS:0]   sum_w;
  logic [WORD_BITS:0]   clip_sum_w;
  logic [WORD_BITS:0]   clip_diff_w;
  logic                 sum_ov;
  logic                 clip_ov;
  logic [WORD_BITS-1:0] sum_sat;
  logic [WORD_BITS-1:0] clip_sat;

  div_t                 div0_r;
  div_t                 div_s   [DIV_BITS+1];
  item_t                it_dv_r [DIV_BITS+1];

  item_t                it_q_nxt;
  item_t                it_q_r;
  quo_t                 quo_nxt;
  quo_t                 quo_r;
  logic [DIV_BITS-1:0]  quo0;
  logic [DIV_BITS-1:0]  quo1;
  logic [DIV_BITS-1:0]  quo2;
  logic [WORD_BITS-1:0] q_lim;
  logic                 q_over;
  logic [WORD_BITS-1:0] q_val;
  logic                 r1_over;
  logic                 r2_over;
  logic [WORD_BITS+1:0] c_w;
  logic [WORD_BITS+1:0] c_neg_w;
  logic                 c_hi;
  logic                 c_lo;

  item_t                it_m1_r;
  prod_t                prod_r;

  item_t                it_m2_nxt;
  item_t                it_m2_r;
  sqop_t                sqop_nxt;
  sqop_t                sqop_r;
  logic [WORD_BITS-1:0] mv_lim;
  logic                 mv_over;
  logic [WORD_BITS-1:0] mv_mag;
  logic [ERR_BITS-1:0]  p1;
  logic [ERR_BITS-1:0]  p2;
  logic [ERR_BITS-1:0]  uu;
  logic [ERR_BITS-1:0]  vv;
  logic                 mul_ov;
  logic                 div_ov;

  item_t                it_m3_r;
  sqres_t               sqres_r;

  sqrt_t                arg_nxt;
  logic [ARG_BITS-1:0]  arg_e;
  logic [ARG_BITS-1:0]  arg_v;
  logic [ARG_BITS-1:0]  sxe;
  logic [ARG_BITS-1:0]  sye;
  logic [ARG_BITS-1:0]  scve;
  sqrt_t                sq0_r;
  sqrt_t                sq_s    [ROOT_BITS+1];
  item_t                it_sq_r [ROOT_BITS+1];

  item_t                fin_it;
  logic [WORD_BITS-1:0] root_e;
  logic [WORD_BITS-1:0] root_v;
  logic                 re_over;
  logic                 fin_ovf;
  logic [WORD_BITS-1:0] out_value_nxt;
  logic [WORD_BITS-1:0] out_error_nxt;
  logic [STAT_BITS-1:0] out_status_nxt;
  logic [WORD_BITS-1:0] out_value_r;
  logic [WORD_BITS-1:0] out_error_r;
  logic [STAT_BITS-1:0] out_status_r;
  func_t                out_func_r;

  // pipeline holds while the output register is full and stalled
  assign in_stall = vld_r[STAGES-1] && out_stall;
  assign adv      = !in_stall;
  assign vld_nxt  = {vld_r[STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // decode: magnitudes, add/sub, clip, division by zero
  always_comb begin
    a_ext       = {in_value_a[WORD_BITS-1], in_value_a};
    b_ext       = {in_value_b[WORD_BITS-1], in_value_b};
    sum_w       = (in_func == FN_SUB) ? a_ext - b_ext : a_ext + b_ext;
    sum_ov      = sum_w[WORD_BITS] != sum_w[WORD_BITS-1];
    sum_sat     = sum_ov ? (sum_w[WORD_BITS] ? NEG_MAG : POS_MAX) : sum_w[WORD_BITS-1:0];
    clip_sum_w  = {2'b00, in_error_a} + a_ext;
    clip_diff_w = ONE_X - a_ext;
    clip_ov     = clip_diff_w[WORD_BITS] != clip_diff_w[WORD_BITS-1];
    clip_sat    = clip_ov ? (clip_diff_w[WORD_BITS] ? NEG_MAG : POS_MAX)
                          : clip_diff_w[WORD_BITS-1:0];

    dec_it.func     = func_t'(in_func);
    dec_it.val_a    = in_value_a;
    dec_it.err_a    = in_error_a;
    dec_it.err_b    = in_error_b;
    dec_it.mag_a    = in_value_a[WORD_BITS-1] ? (~in_value_a + 1'b1) : in_value_a;
    dec_it.mag_b    = in_value_b[WORD_BITS-1] ? (~in_value_b + 1'b1) : in_value_b;
    dec_it.neg      = in_value_a[WORD_BITS-1] ^ in_value_b[WORD_BITS-1];
    dec_it.rv       = in_value_a;
    dec_it.re       = {1'b0, in_error_a};
    dec_it.re_fixed = 1'b1;
    dec_it.ovf      = 1'b0;
    dec_it.negroot  = 1'b0;

    case (func_t'(in_func))
      FN_ADD, FN_SUB: begin
        dec_it.rv       = sum_sat;
        dec_it.ovf      = sum_ov;
        dec_it.re_fixed = 1'b0;
      end
      FN_MUL: begin
        dec_it.re_fixed = 1'b0;
      end
      FN_DIV: begin
        if (in_value_b == '0) begin
          dec_it.rv = (in_value_a == '0) ? ONE_Q : '0;
          dec_it.re = (in_value_a == '0) ? ONE_Q : '0;
        end else begin
          dec_it.re_fixed = 1'b0;
        end
      end
      FN_SQRT: begin
        dec_it.negroot  = in_value_a[WORD_BITS-1];
        dec_it.re_fixed = 1'b0;
      end
      FN_CLIP: begin
        if ($signed(clip_sum_w) > $signed(ONE_X)) begin
          dec_it.re  = clip_sat;
          dec_it.ovf = clip_ov;
        end
      end
      default: begin
      end
    endcase

    // dividends are scaled by one
    dec_div.dvsr = dec_it.mag_b;
    dec_div.lane[LN_QUO].rem = '0;
    dec_div.lane[LN_QUO].num = {dec_it.mag_a, {FRAC_BITS{1'b0}}};
    dec_div.lane[LN_EA].rem  = '0;
    dec_div.lane[LN_EA].num  = {1'b0, in_error_a, {FRAC_BITS{1'b0}}};
    dec_div.lane[LN_EB].rem  = '0;
    dec_div.lane[LN_EB].num  = {1'b0, in_error_b, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div0_r <= dec_div;
    end
  end

  assign div_s[0] = div0_r;

  // divider row
  for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
    hba_div_cell u_div_cell (
      .clk     (clk),
      .en      (adv),
      .div_in  (div_s[g]),
      .div_out (div_s[g+1])
    );
  end

  // side data beside the divider row
  always_ff @(posedge clk) begin
    if (adv) begin
      it_dv_r[0] <= dec_it;
      for (int i = 1; i <= DIV_BITS; i++) begin
        it_dv_r[i] <= it_dv_r[i-1];
      end
    end
  end

  // quotient saturation and c = 1 - 2q
  always_comb begin
    quo0    = div_s[DIV_BITS].lane[LN_QUO].num;
    quo1    = div_s[DIV_BITS].lane[LN_EA].num;
    quo2    = div_s[DIV_BITS].lane[LN_EB].num;
    q_lim   = it_dv_r[DIV_BITS].neg ? NEG_MAG : POS_MAX;
    q_over  = quo0 > {{FRAC_BITS{1'b0}}, q_lim};
    r1_over = quo1 > {{FRAC_BITS{1'b0}}, POS_MAX};
    r2_over = quo2 > {{FRAC_BITS{1'b0}}, POS_MAX};
    quo_nxt.qm = q_over ? q_lim : quo0[WORD_BITS-1:0];
    quo_nxt.r1 = r1_over ? POS_MAX[ERR_BITS-1:0] : quo1[ERR_BITS-1:0];
    quo_nxt.r2 = r2_over ? POS_MAX[ERR_BITS-1:0] : quo2[ERR_BITS-1:0];
    q_val   = it_dv_r[DIV_BITS].neg ? (~quo_nxt.qm + 1'b1) : quo_nxt.qm;
    c_w     = {1'b0, ONE_X} - {q_val[WORD_BITS-1], q_val, 1'b0};
    c_neg_w = ~c_w + 1'b1;
    c_hi    = $signed(c_w) > $signed({2'b00, POS_MAX});
    c_lo    = $signed(c_w) < $signed({2'b11, NEG_MAG});
    quo_nxt.cneg = c_w[WORD_BITS+1];
    if (c_hi) begin
      quo_nxt.cm = POS_MAX;
    end else if (c_lo) begin
      quo_nxt.cm = NEG_MAG;
    end else if (c_w[WORD_BITS+1]) begin
      quo_nxt.cm = c_neg_w[WORD_BITS-1:0];
    end else begin
      quo_nxt.cm = c_w[WORD_BITS-1:0];
    end

    it_q_nxt = it_dv_r[DIV_BITS];
    if (it_dv_r[DIV_BITS].func == FN_DIV && !it_dv_r[DIV_BITS].re_fixed) begin
      it_q_nxt.rv  = q_val;
      it_q_nxt.ovf = q_over | r1_over | r2_over | c_hi | c_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_q_r <= it_q_nxt;
      quo_r  <= quo_nxt;
    end
  end

  // first products
  always_ff @(posedge clk) begin
    if (adv) begin
      it_m1_r     <= it_q_r;
      prod_r.pab  <= it_q_r.mag_a * it_q_r.mag_b;
      prod_r.paeb <= it_q_r.mag_a * it_q_r.err_b;
      prod_r.pbea <= it_q_r.mag_b * it_q_r.err_a;
      prod_r.pqr  <= quo_r.qm * quo_r.r2;
      prod_r.pr1  <= quo_r.r1 * quo_r.r1;
      prod_r.cm   <= quo_r.cm;
      prod_r.cneg <= quo_r.cneg;
    end
  end

  // rescale products, pick square operands
  always_comb begin
    mv_lim  = it_m1_r.neg ? NEG_MAG : POS_MAX;
    mv_over = (prod_r.pab >> FRAC_BITS) > {{WORD_BITS{1'b0}}, mv_lim};
    mv_mag  = mv_over ? mv_lim : prod_r.pab[FRAC_BITS +: WORD_BITS];
    p1      = sat_err({1'b0, prod_r.paeb} >> FRAC_BITS);
    p2      = sat_err({1'b0, prod_r.pbea} >> FRAC_BITS);
    uu      = sat_err({1'b0, prod_r.pqr} >> FRAC_BITS);
    vv      = sat_err({2'b00, prod_r.pr1} >> FRAC_BITS);
    mul_ov  = mv_over | over_err({1'b0, prod_r.paeb} >> FRAC_BITS)
                      | over_err({1'b0, prod_r.pbea} >> FRAC_BITS);
    div_ov  = over_err({1'b0, prod_r.pqr} >> FRAC_BITS)
            | over_err({2'b00, prod_r.pr1} >> FRAC_BITS);

    it_m2_nxt     = it_m1_r;
    sqop_nxt.x    = '0;
    sqop_nxt.y    = '0;
    sqop_nxt.v    = vv;
    sqop_nxt.cm   = prod_r.cm;
    sqop_nxt.cneg = prod_r.cneg;
    case (it_m1_r.func)
      FN_ADD, FN_SUB: begin
        sqop_nxt.x = it_m1_r.err_a;
        sqop_nxt.y = it_m1_r.err_b;
      end
      FN_MUL: begin
        sqop_nxt.x    = p1;
        sqop_nxt.y    = p2;
        it_m2_nxt.rv  = it_m1_r.neg ? (~mv_mag + 1'b1) : mv_mag;
        it_m2_nxt.ovf = it_m1_r.ovf | mul_ov;
      end
      FN_DIV: begin
        sqop_nxt.x = uu;
        if (!it_m1_r.re_fixed) begin
          it_m2_nxt.ovf = it_m1_r.ovf | div_ov;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_m2_r <= it_m2_nxt;
      sqop_r  <= sqop_nxt;
    end
  end

  // squares and c*v
  always_ff @(posedge clk) begin
    if (adv) begin
      it_m3_r      <= it_m2_r;
      sqres_r.sx   <= sqop_r.x * sqop_r.x;
      sqres_r.sy   <= sqop_r.y * sqop_r.y;
      sqres_r.scv  <= sqop_r.cm * sqop_r.v;
      sqres_r.cneg <= sqop_r.cneg;
    end
  end

  // root arguments
  always_comb begin
    sxe   = {2'b00, sqres_r.sx};
    sye   = {2'b00, sqres_r.sy};
    scve  = {1'b0, sqres_r.scv};
    arg_e = '0;
    arg_v = '0;
    case (it_m3_r.func)
      FN_ADD, FN_SUB, FN_MUL: begin
        arg_e = sxe + sye;
      end
      FN_DIV: begin
        if (!sqres_r.cneg) begin
          arg_e = sxe + scve;
        end else if (sxe >= scve) begin
          arg_e = sxe - scve;
        end else begin
          arg_e = scve - sxe;
        end
      end
      FN_SQRT: begin
        arg_e = {{(ARG_BITS-ERR_BITS-FRAC_BITS){1'b0}}, it_m3_r.err_a, {FRAC_BITS{1'b0}}};
        if (!it_m3_r.negroot) begin
          arg_v = {{(ARG_BITS-WORD_BITS-FRAC_BITS){1'b0}}, it_m3_r.val_a,
                   {FRAC_BITS{1'b0}}};
        end
      end
      default: begin
      end
    endcase
    arg_nxt.lane[LN_ERR].arg  = arg_e;
    arg_nxt.lane[LN_ERR].rem  = '0;
    arg_nxt.lane[LN_ERR].root = '0;
    arg_nxt.lane[LN_VAL].arg  = arg_v;
    arg_nxt.lane[LN_VAL].rem  = '0;
    arg_nxt.lane[LN_VAL].root = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq0_r <= arg_nxt;
    end
  end

  assign sq_s[0] = sq0_r;

  // root row
  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_sqrt
    hba_sqrt_cell u_sqrt_cell (
      .clk    (clk),
      .en     (adv),
      .sq_in  (sq_s[g]),
      .sq_out (sq_s[g+1])
    );
  end

  // side data beside the root row
  always_ff @(posedge clk) begin
    if (adv) begin
      it_sq_r[0] <= it_m3_r;
      for (int i = 1; i <= ROOT_BITS; i++) begin
        it_sq_r[i] <= it_sq_r[i-1];
      end
    end
  end

  // final select, error saturation and status
  always_comb begin
    fin_it  = it_sq_r[ROOT_BITS];
    root_e  = sq_s[ROOT_BITS].lane[LN_ERR].root;
    root_v  = sq_s[ROOT_BITS].lane[LN_VAL].root;
    re_over = root_e > POS_MAX;
    fin_ovf = fin_it.ovf | (!fin_it.re_fixed & re_over);
    out_error_nxt = fin_it.re_fixed ? fin_it.re : (re_over ? POS_MAX : root_e);
    out_value_nxt = (fin_it.func == FN_SQRT) ? root_v : fin_it.rv;
    if (fin_it.negroot) begin
      out_status_nxt = ST_NEGROOT;
    end else if (fin_ovf) begin
      out_status_nxt = ST_SAT;
    end else begin
      out_status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r  <= out_value_nxt;
      out_error_r  <= out_error_nxt;
      out_status_r <= out_status_nxt;
      out_func_r   <= fin_it.func;
    end
  end

  assign out_valid        = vld_r[STAGES-1];
  assign out_result_value = out_value_r;
  assign out_result_error = out_error_r;
  assign out_status       = out_status_r;

  // checks
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(vld_r))
    else $error("pipeline moved while output stalled");

  a_take_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("taken request did not enter the pipeline");

  a_negroot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NEGROOT |-> out_result_value == '0)
    else $error("negative root argument not clamped to zero");

  a_error_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_func_r != FN_CLIP |-> !out_result_error[WORD_BITS-1])
    else $error("negative error outside efficiency clip");

endmodule

// ===== verif/tb_histogram_bin_arithmetic_with_errors.sv =====
// self-checking testbench for the histogram bin arithmetic block
`timescale 1ns / 1ps

module tb_histogram_bin_arithmetic_with_errors;
  import hba_pkg::*;

  localparam int LATENCY   = STAGES;
  localparam int LIMIT     = 400000;
  localparam int N_RANDOM  = 750;
  localparam logic [2:0] FN_PASS6 = 3'd6;
  localparam logic [2:0] FN_PASS7 = 3'd7;
  localparam logic signed [31:0] VMAX = 32'sh7fffffff;
  localparam logic signed [31:0] VMIN = 32'sh80000000;
  localparam logic [30:0] EMAX = 31'h7fffffff;

  typedef struct {
    logic [2:0]         func;
    logic signed [31:0] va;
    logic [30:0]        ea;
    logic signed [31:0] vb;
    logic [30:0]        eb;
  } bin_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] error;
    logic [1:0]  status;
  } bin_res_t;

  // directed row: request plus optional hand-typed answer
  typedef struct {
    bin_req_t req;
    bit       typed;
    bin_res_t res;
  } dir_row_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  in_func = '0;
  logic signed [31:0] in_value_a = '0;
  logic [30:0] in_error_a = '0;
  logic signed [31:0] in_value_b = '0;
  logic [30:0] in_error_b = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic signed [31:0] out_result_value;
  logic signed [31:0] out_result_error;
  logic [1:0]  out_status;

  bin_res_t pending_results[$];
  int       n_mismatch = 0;
  int       cycle = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  bit       done = 0;

  histogram_bin_arithmetic_with_errors DUT (.*);

  // clock
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // integer square root of a 128-bit value
  function automatic logic [63:0] isqrt128(logic [127:0] x);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= x) r = c;
    end
    return r;
  endfunction

  // clamp a magnitude to a limit, flagging overflow
  function automatic logic [63:0] clamp_mag(logic [127:0] m, logic [63:0] lim, ref bit ovf);
    if (m > 128'(lim)) begin
      ovf = 1;
      return lim;
    end
    return m[63:0];
  endfunction

  function automatic longint signed with_sign(bit neg, logic [127:0] m, ref bit ovf);
    if (neg) return -longint'(clamp_mag(m, 64'h80000000, ovf));
    return longint'(clamp_mag(m, 64'h7fffffff, ovf));
  endfunction

  function automatic longint signed clamp_s(longint signed x, ref bit ovf);
    if (x > 64'sh7fffffff) begin
      ovf = 1;
      return 64'sh7fffffff;
    end
    if (x < -64'sh80000000) begin
      ovf = 1;
      return -64'sh80000000;
    end
    return x;
  endfunction

  function automatic logic [63:0] absv(longint signed x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // predicted result for one bin pair
  function automatic bin_res_t predict_bin(bin_req_t r);
    bin_res_t o;
    bit ovf, negroot;
    longint signed a, b, rv, re, q, c;
    logic [63:0] ea, eb, p1, p2, bm, r1, r2, u, v, av;
    logic [127:0] cv, uu, n;
    a = r.va; b = r.vb; ea = r.ea; eb = r.eb;
    ovf = 0; negroot = 0;
    rv = a; re = longint'(ea);
    case (r.func)
      FN_ADD, FN_SUB: begin
        rv = clamp_s(r.func == FN_ADD ? a + b : a - b, ovf);
        re = longint'(clamp_mag(isqrt128(128'(ea) * ea + 128'(eb) * eb), 64'h7fffffff, ovf));
      end
      FN_MUL: begin
        rv = with_sign((a < 0) != (b < 0), (128'(absv(a)) * absv(b)) >> FRAC_BITS, ovf);
        p1 = clamp_mag((128'(absv(a)) * eb) >> FRAC_BITS, 64'h7fffffff, ovf);
        p2 = clamp_mag((128'(absv(b)) * ea) >> FRAC_BITS, 64'h7fffffff, ovf);
        re = longint'(clamp_mag(isqrt128(128'(p1) * p1 + 128'(p2) * p2), 64'h7fffffff, ovf));
      end
      FN_DIV: begin
        if (b == 0) begin
          rv = (a == 0) ? longint'(ONE_Q) : 0;
          re = rv;
        end else begin
          bm = absv(b);
          q  = with_sign((a < 0) != (b < 0), (128'(absv(a)) << FRAC_BITS) / bm, ovf);
          r1 = clamp_mag((128'(ea) << FRAC_BITS) / bm, 64'h7fffffff, ovf);
          r2 = clamp_mag((128'(eb) << FRAC_BITS) / bm, 64'h7fffffff, ovf);
          u  = clamp_mag((128'(absv(q)) * r2) >> FRAC_BITS, 64'h7fffffff, ovf);
          v  = clamp_mag((128'(r1) * r1) >> FRAC_BITS, 64'h7fffffff, ovf);
          c  = clamp_s(longint'(ONE_Q) - 2 * q, ovf);
          cv = 128'(absv(c)) * v;
          uu = 128'(u) * u;
          if (c < 0) n = (uu >= cv) ? uu - cv : cv - uu;
          else n = uu + cv;
          rv = q;
          re = longint'(clamp_mag(isqrt128(n), 64'h7fffffff, ovf));
        end
      end
      FN_SQRT: begin
        av = 0;
        if (a < 0) negroot = 1;
        else av = 64'(a);
        rv = longint'(clamp_mag(isqrt128(128'(av) << FRAC_BITS), 64'h7fffffff, ovf));
        re = longint'(clamp_mag(isqrt128(128'(ea) << FRAC_BITS), 64'h7fffffff, ovf));
      end
      FN_CLIP: begin
        if (longint'(ea) + a > longint'(ONE_Q)) re = clamp_s(longint'(ONE_Q) - a, ovf);
      end
      default: ;
    endcase
    o.value  = rv[31:0];
    o.error  = re[31:0];
    o.status = negroot ? ST_NEGROOT : (ovf ? ST_SAT : ST_OK);
    return o;
  endfunction

  function automatic bin_req_t mk_req(logic [2:0] f, logic signed [31:0] va, logic [30:0] ea,
                                      logic signed [31:0] vb, logic [30:0] eb);
    bin_req_t r;
    r.func = f; r.va = va; r.ea = ea; r.vb = vb; r.eb = eb;
    return r;
  endfunction

  function automatic bin_res_t mk_res(logic [31:0] v, logic [31:0] e, logic [1:0] s);
    bin_res_t o;
    o.value = v; o.error = e; o.status = s;
    return o;
  endfunction

  // random operand value, biased toward small magnitudes and edges
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 3) == 0 ? 32'h7fffffff : 32'h80000000;
      2: return $urandom_range(0, 4) == 0 ? 32'd0 : 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
      default: return 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
    endcase
  endfunction

  // send one request, idling at random before it
  task automatic send_bin(bin_req_t r);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid   <= 1;
    in_func    <= r.func;
    in_value_a <= r.va;
    in_error_a <= r.ea;
    in_value_b <= r.vb;
    in_error_b <= r.eb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait for the clock, then until every expected result has arrived
  task automatic drain();
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // record accepted requests
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pending_results = {pending_results, predict_bin(mk_req(in_func, in_value_a, in_error_a,
                                                             in_value_b, in_error_b))};
  end

  // compare results against the oldest expectation
  always @(posedge clk) begin
    bin_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %h %h %0d",
                                       out_result_value, out_result_error, out_status);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.value !== out_result_value || exp_r.error !== out_result_error ||
            exp_r.status !== out_status) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp %h %h %0d got %h %h %0d", exp_r.value, exp_r.error,
                     exp_r.status, out_result_value, out_result_error, out_status);
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // timeout
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= LIMIT && !done) begin
      $display("FAIL");
      $finish;
    end
  end

  dir_row_t dir_rows[$];
  dir_row_t row;
  bin_req_t rq;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // directed table: extremes, every op, special cases
    dir_rows = '{
      '{mk_req(FN_ADD, 0, 0, 0, 0), 1, mk_res(0, 0, ST_OK)},
      '{mk_req(FN_ADD, VMAX, 0, VMAX, 0), 1, mk_res(32'h7fffffff, 0, ST_SAT)},
      '{mk_req(FN_SUB, VMIN, 0, 1, 0), 1, mk_res(32'h80000000, 0, ST_SAT)},
      '{mk_req(FN_ADD, 1, EMAX, 1, EMAX), 1, mk_res(2, 32'h7fffffff, ST_SAT)},
      '{mk_req(FN_SUB, 32'h00030000, 3 << 16, 32'h00010000, 4 << 16), 1,
        mk_res(32'h00020000, 32'h00050000, ST_OK)},
      '{mk_req(FN_MUL, 32'h00020000, 1 << 16, 32'hfffd0000, 1 << 16), 0, '{default: 0}},
      '{mk_req(FN_MUL, VMIN, EMAX, VMIN, EMAX), 0, '{default: 0}},
      '{mk_req(FN_MUL, VMAX, 0, VMIN, 0), 0, '{default: 0}},
      '{mk_req(FN_DIV, 0, 5, 0, 7), 1, mk_res(32'h00010000, 32'h00010000, ST_OK)},
      '{mk_req(FN_DIV, 32'h00050000, 5, 0, 7), 1, mk_res(0, 0, ST_OK)},
      '{mk_req(FN_DIV, 32'h00010000, 1 << 12, 32'h00040000, 1 << 14), 0, '{default: 0}},
      '{mk_req(FN_DIV, VMIN, EMAX, 1, EMAX), 0, '{default: 0}},
      '{mk_req(FN_DIV, VMAX, EMAX, -1, 1), 0, '{default: 0}},
      '{mk_req(FN_SQRT, 32'h00040000, 4 << 16, 0, 0), 1,
        mk_res(32'h00020000, 32'h00020000, ST_OK)},
      '{mk_req(FN_SQRT, -1, 1 << 16, 9, 9), 1, mk_res(0, 32'h00010000, ST_NEGROOT)},
      '{mk_req(FN_SQRT, VMAX, EMAX, VMIN, EMAX), 0, '{default: 0}},
      '{mk_req(FN_CLIP, 32'h0000c000, 32'h00008000, 0, 0), 1,
        mk_res(32'h0000c000, 32'h00004000, ST_OK)},
      '{mk_req(FN_CLIP, 32'h00004000, 32'h00004000, 0, 0), 1,
        mk_res(32'h00004000, 32'h00004000, ST_OK)},
      '{mk_req(FN_CLIP, VMIN, EMAX, 0, 0), 0, '{default: 0}},
      '{mk_req(FN_PASS6, VMIN, EMAX, VMAX, 0), 1, mk_res(32'h80000000, 32'h7fffffff, ST_OK)},
      '{mk_req(FN_PASS7, VMAX, 0, VMIN, EMAX), 1, mk_res(32'h7fffffff, 0, ST_OK)}
    };
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      // hand-typed answers must agree with the predictor
      if (row.typed && predict_bin(row.req) !== row.res) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("directed row %0d: typed answer differs", i);
      end
      send_bin(row.req);
    end
    in_valid <= 0;
    drain();

    // random requests over the idling and stalling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      for (int k = 0; k < N_RANDOM / 4; k++) begin
        rq.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
        rq.va = rand_word();
        rq.vb = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_word();
        rq.ea = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'(rand_word() & 32'h00ffffff);
        rq.eb = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'(rand_word() & 32'h00ffffff);
        send_bin(rq);
      end
      in_valid <= 0;
      drain();
    end
    stall_pct = 0;
    repeat (LATENCY + 20) @(posedge clk);
    done = 1;
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/hba_pkg.sv
rtl/hba_div_cell.sv
rtl/hba_sqrt_cell.sv
rtl/histogram_bin_arithmetic_with_errors.sv
verif/tb_histogram_bin_arithmetic_with_errors.sv
